// ===== hdl/sbcpt_pkg.sv =====
// Shared constants, register indexes and controller command type for the bin change pulse trigger.
`default_nettype none

package sbcpt_pkg;

	// Field widths.
	localparam int SAMPLE_BITS = 12;
	localparam int BIN_BITS    = 8;
	localparam int FRAC_BITS   = 16;
	localparam int FILT_W      = SAMPLE_BITS + FRAC_BITS;
	localparam int WGT_W       = FRAC_BITS + 1;
	localparam int PA_W        = WGT_W + FILT_W;
	localparam int PB_W        = WGT_W + SAMPLE_BITS;
	localparam int ACC_W       = PA_W + 1;
	localparam int NUM_W       = SAMPLE_BITS + BIN_BITS;
	localparam int STEP_W      = $clog2(NUM_W);
	localparam int EL_W        = 20;
	localparam int CFG_W       = 20;
	localparam int CFG_IDX_W   = 3;

	// Unity weight in Q1.16 and the saturation limit of the elapsed counter.
	localparam logic [WGT_W-1:0] ONE_Q  = WGT_W'(1) << FRAC_BITS;
	localparam logic [EL_W-1:0]  EL_MAX = '1;

	// Operation codes of an input beat.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_WEIGHT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LENGTH_US = 3'd4;

	// Reset values of the configuration registers.
	localparam logic [WGT_W-1:0]       WGT_RST = WGT_W'(6554);
	localparam logic [SAMPLE_BITS-1:0] MIN_RST = '0;
	localparam logic [SAMPLE_BITS-1:0] MAX_RST = '1;
	localparam logic [BIN_BITS-1:0]    TOP_RST = BIN_BITS'(10);
	localparam logic [EL_W-1:0]        LEN_RST = EL_W'(10000);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic map;
		logic div_step;
		logic commit;
		logic tick;
	} cmd_t;

endpackage

`default_nettype wire

// ===== hdl/sbcpt_ctrl.sv =====
// Sequencing controller: accepts a beat, steps the datapath and holds the output valid.
`default_nettype none

module sbcpt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic          op,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sbcpt_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_MAP,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                         state_q;
	logic [sbcpt_pkg::STEP_W-1:0]   cnt_q;
	logic                           op_q;
	logic                           out_valid_q;
	logic                           commit_ok;

	// The result register can be loaded when it is empty or being taken.
	assign commit_ok = !out_valid_q || !out_stall;

	// State, step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			op_q        <= sbcpt_pkg::OP_SAMPLE;
			out_valid_q <= 1'b0;
		end else begin
			// The result register fills on commit and empties when its beat is taken.
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= op;
						state_q <= (op == sbcpt_pkg::OP_TICK) ? ST_FIN : ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_SUM;
				ST_SUM: state_q <= ST_MAP;
				ST_MAP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == sbcpt_pkg::STEP_W'(sbcpt_pkg::NUM_W - 1)) begin
						state_q <= ST_FIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (commit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.mul      = (state_q == ST_MUL);
		cmd.sum      = (state_q == ST_SUM);
		cmd.map      = (state_q == ST_MAP);
		cmd.div_step = (state_q == ST_DIV);
		cmd.commit   = (state_q == ST_FIN) && commit_ok;
		cmd.tick     = (op_q == sbcpt_pkg::OP_TICK);
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/sbcpt_dp.sv =====
// Datapath: configuration registers, filter, linear map with serial divider, and pulse timer.
`default_nettype none

module sbcpt_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire sbcpt_pkg::cmd_t                       cmd,
	input  wire logic [sbcpt_pkg::SAMPLE_BITS-1:0]     sample,
	input  wire logic                                  cfg_we,
	input  wire logic [sbcpt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [sbcpt_pkg::CFG_W-1:0]           cfg_data,
	output logic [sbcpt_pkg::BIN_BITS-1:0]             bin,
	output logic                                       vibrating,
	output logic                                       pulse_started,
	output logic                                       pulse_stopped
);

	localparam int SB = sbcpt_pkg::SAMPLE_BITS;
	localparam int BB = sbcpt_pkg::BIN_BITS;
	localparam int NW = sbcpt_pkg::NUM_W;
	localparam int EW = sbcpt_pkg::EL_W;

	// Configuration registers.
	logic [sbcpt_pkg::WGT_W-1:0] wgt_q;
	logic [SB-1:0]               lo_q;
	logic [SB-1:0]               hi_q;
	logic [BB-1:0]               top_q;
	logic [EW-1:0]               len_q;

	// Block state.
	logic [sbcpt_pkg::FILT_W-1:0] filt_q;
	logic [BB-1:0]                last_bin_q;
	logic                         active_q;
	logic [EW-1:0]                elapsed_q;

	// Working registers.
	logic [SB-1:0]                x_q;
	logic [sbcpt_pkg::PA_W-1:0]   pa_q;
	logic [sbcpt_pkg::PB_W-1:0]   pb_q;
	logic [SB-1:0]                rem_q;
	logic [NW-1:0]                dnd_q;
	logic [SB-1:0]                den_q;
	logic                         force_zero_q;

	// Result registers.
	logic [BB-1:0]                bin_q;
	logic                         vib_q;
	logic                         started_q;
	logic                         stopped_q;

	// Filter terms.
	logic [sbcpt_pkg::WGT_W-1:0]  w_eff;
	logic [sbcpt_pkg::WGT_W-1:0]  w_rest;
	logic [sbcpt_pkg::ACC_W-1:0]  acc;

	// Map terms.
	logic [SB-1:0]                v;
	logic [SB:0]                  diff;
	logic [SB:0]                  span;
	logic [SB-1:0]                diff_mag;
	logic [SB-1:0]                span_mag;
	logic [NW-1:0]                num;

	// Divider step terms.
	logic [SB:0]                  trial;
	logic                         qbit;
	logic [SB:0]                  trial_sub;

	// Commit terms.
	logic [BB-1:0]                nb;
	logic                         changed;
	logic [BB-1:0]                bin_n;
	logic [EW-1:0]                el_n;
	logic                         act_a;
	logic                         stop_n;

	// A weight above one counts as one.
	assign w_eff  = wgt_q[sbcpt_pkg::FRAC_BITS] ? sbcpt_pkg::ONE_Q : wgt_q;
	assign w_rest = sbcpt_pkg::ONE_Q - w_eff;
	assign acc    = sbcpt_pkg::ACC_W'(pa_q)
	              + sbcpt_pkg::ACC_W'({pb_q, {sbcpt_pkg::FRAC_BITS{1'b0}}});

	// Offset and span of the map, as sign and magnitude.
	assign v        = filt_q[sbcpt_pkg::FILT_W-1 -: SB];
	assign diff     = {1'b0, v} - {1'b0, lo_q};
	assign span     = {1'b0, hi_q} - {1'b0, lo_q};
	assign diff_mag = diff[SB] ? SB'(-diff) : diff[SB-1:0];
	assign span_mag = span[SB] ? SB'(-span) : span[SB-1:0];
	assign num      = NW'(diff_mag) * NW'(top_q);

	// One restoring division step per cycle.
	assign trial     = {rem_q, dnd_q[NW-1]};
	assign qbit      = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};

	// Saturated bin and pulse update for the item being finished.
	always_comb begin
		if (force_zero_q) begin
			nb = '0;
		end else if (dnd_q > NW'(top_q)) begin
			nb = top_q;
		end else begin
			nb = dnd_q[BB-1:0];
		end
		changed = !cmd.tick && (nb != last_bin_q);
		bin_n   = changed ? nb : last_bin_q;
		if (changed) begin
			el_n = '0;
		end else if (cmd.tick && active_q && (elapsed_q != sbcpt_pkg::EL_MAX)) begin
			el_n = elapsed_q + 1'b1;
		end else begin
			el_n = elapsed_q;
		end
		act_a  = changed || active_q;
		stop_n = act_a && (el_n >= len_q);
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wgt_q <= sbcpt_pkg::WGT_RST;
			lo_q  <= sbcpt_pkg::MIN_RST;
			hi_q  <= sbcpt_pkg::MAX_RST;
			top_q <= sbcpt_pkg::TOP_RST;
			len_q <= sbcpt_pkg::LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sbcpt_pkg::CFG_FILTER_WEIGHT:   wgt_q <= cfg_data[sbcpt_pkg::WGT_W-1:0];
				sbcpt_pkg::CFG_RANGE_MIN:       lo_q  <= cfg_data[SB-1:0];
				sbcpt_pkg::CFG_RANGE_MAX:       hi_q  <= cfg_data[SB-1:0];
				sbcpt_pkg::CFG_BIN_COUNT:       top_q <= cfg_data[BB-1:0];
				sbcpt_pkg::CFG_PULSE_LENGTH_US: len_q <= cfg_data[EW-1:0];
				default: ;
			endcase
		end
	end

	// Filter value, last bin and pulse timer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_q     <= '0;
			last_bin_q <= '0;
			active_q   <= 1'b0;
			elapsed_q  <= '0;
		end else begin
			if (cmd.sum) begin
				filt_q <= acc[sbcpt_pkg::FRAC_BITS +: sbcpt_pkg::FILT_W];
			end
			if (cmd.commit) begin
				last_bin_q <= bin_n;
				elapsed_q  <= el_n;
				active_q   <= act_a && !stop_n;
			end
		end
	end

	// Sample capture, products, divider and result beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= sample;
		end
		if (cmd.mul) begin
			pa_q <= sbcpt_pkg::PA_W'(w_rest) * sbcpt_pkg::PA_W'(filt_q);
			pb_q <= sbcpt_pkg::PB_W'(w_eff) * sbcpt_pkg::PB_W'(x_q);
		end
		if (cmd.map) begin
			rem_q        <= '0;
			dnd_q        <= num;
			den_q        <= span_mag;
			force_zero_q <= (hi_q == lo_q) || (diff[SB] != span[SB]);
		end else if (cmd.div_step) begin
			rem_q <= qbit ? trial_sub[SB-1:0] : trial[SB-1:0];
			dnd_q <= {dnd_q[NW-2:0], qbit};
		end
		if (cmd.commit) begin
			bin_q     <= bin_n;
			vib_q     <= act_a && !stop_n;
			started_q <= changed;
			stopped_q <= stop_n;
		end
	end

	assign bin           = bin_q;
	assign vibrating     = vib_q;
	assign pulse_started = started_q;
	assign pulse_stopped = stopped_q;

endmodule

`default_nettype wire

// ===== hdl/sensor_bin_change_pulse_trigger_unit.sv =====
// Top level of the sensor bin change pulse trigger.
//
// Each input beat is a 12-bit ADC sample (op 0) or a one-microsecond tick (op 1), and each
// gives exactly one result beat with the current bin, the vibrating flag and the pulse start
// and stop events. A sample is filtered by an exponential filter in 12.16 fixed point, mapped
// linearly from [range_min, range_max] onto [0, bin_count] and saturated. A sample passes, in
// order, through the filter multiply, the filter sum, the map setup, the one-bit-per-cycle
// restoring divider that scales the map, and the pulse timer update. A tick goes straight to
// the pulse timer update and skips the filter, map and divider. The input is taken only
// while no item is in progress, and a finished result waits in its own output register, so
// the next beat is accepted while that result is still stalled. Configuration registers are
// written through cfg_we, cfg_index and cfg_data and should only be changed while idle.
`default_nettype none

module sensor_bin_change_pulse_trigger_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               op,
	input  wire logic [sbcpt_pkg::SAMPLE_BITS-1:0]  sample,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [sbcpt_pkg::BIN_BITS-1:0]          bin,
	output logic                                    vibrating,
	output logic                                    pulse_started,
	output logic                                    pulse_stopped,
	input  wire logic                               cfg_we,
	input  wire logic [sbcpt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sbcpt_pkg::CFG_W-1:0]        cfg_data
);

	sbcpt_pkg::cmd_t cmd;

	// Controller.
	sbcpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath.
	sbcpt_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sample        (sample),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.bin           (bin),
		.vibrating     (vibrating),
		.pulse_started (pulse_started),
		.pulse_stopped (pulse_stopped)
	);

endmodule

`default_nettype wire

// ===== hdl/sbcpt_check.sv =====
// Port-level assertions for the bin change pulse trigger, bound to the top level.
`default_nettype none

module sbcpt_check (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               in_valid,
	input wire logic                               in_stall,
	input wire logic                               out_valid,
	input wire logic                               out_stall,
	input wire logic [sbcpt_pkg::BIN_BITS-1:0]     bin,
	input wire logic                               vibrating,
	input wire logic                               pulse_started,
	input wire logic                               pulse_stopped
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(bin) && $stable(vibrating)
			&& $stable(pulse_started) && $stable(pulse_stopped))
		else $error("stalled result beat changed");

	// Only one item is worked on at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while an item is in progress");

	// A pulse that ends leaves the output quiet.
	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_stopped |-> !vibrating)
		else $error("pulse stopped but still vibrating");

	// A pulse that starts is vibrating unless it ended at once.
	a_start_vib: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pulse_started |-> vibrating || pulse_stopped)
		else $error("pulse started but neither vibrating nor stopped");

endmodule

bind sensor_bin_change_pulse_trigger_unit sbcpt_check u_check (.*);

`default_nettype wire
